@@ rtl/ils_pkg.sv @@
// Shared types and constants for the indexed list store.
package ils_pkg;

	localparam int OP_W   = 3;
	localparam int IDX_W  = 7;
	localparam int VAL_W  = 32;
	localparam int ST_W   = 2;
	localparam int CNT_W  = 7;
	localparam int WIDE_W = 64;

	// Operation codes
	localparam logic [OP_W-1:0] OP_READ   = 3'd0;
	localparam logic [OP_W-1:0] OP_FRONT  = 3'd1;
	localparam logic [OP_W-1:0] OP_BACK   = 3'd2;
	localparam logic [OP_W-1:0] OP_AT     = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

	// Status codes
	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// Operation class seen by the controller
	localparam logic [1:0] K_READ = 2'd0;
	localparam logic [1:0] K_INS  = 2'd1;
	localparam logic [1:0] K_DEL  = 2'd2;
	localparam logic [1:0] K_BAD  = 2'd3;

	// Read address select
	localparam logic [2:0] RA_IDX    = 3'd0;
	localparam logic [2:0] RA_CNT_M1 = 3'd1;
	localparam logic [2:0] RA_PTR_M1 = 3'd2;
	localparam logic [2:0] RA_PTR_P1 = 3'd3;
	localparam logic [2:0] RA_IDX_P1 = 3'd4;

	// Write address select
	localparam logic [1:0] WA_POS    = 2'd0;
	localparam logic [1:0] WA_PTR_P1 = 2'd1;
	localparam logic [1:0] WA_PTR_M1 = 2'd2;

	typedef struct packed {
		logic       cap;
		logic       rd_en;
		logic [2:0] rd_mode;
		logic       wr_en;
		logic [1:0] wr_mode;
		logic       res_load;
	} ils_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       ok;
		logic       full;
		logic       pos_eq_cnt;
		logic       ptr_eq_pos;
		logic       idx_last;
		logic       ptr_last;
		logic       out_free;
	} ils_stat_t;

endpackage

@@ rtl/ils_dpath.sv @@
// Datapath: request registers, entry memory, shift pointer, count and result register.
module ils_dpath #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ils_pkg::ils_cmd_t                   cmd,
	output ils_pkg::ils_stat_t                  stat,
	input  logic [ils_pkg::OP_W-1:0]            operation,
	input  logic [ils_pkg::IDX_W-1:0]           index,
	input  logic signed [ils_pkg::VAL_W-1:0]    value,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic signed [ils_pkg::VAL_W-1:0]    read_value,
	output logic [ils_pkg::ST_W-1:0]            status,
	output logic [ils_pkg::CNT_W-1:0]           count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > ils_pkg::IDX_W) ? CW : ils_pkg::IDX_W) + 1;

	logic [VALUE_BITS-1:0]         mem [CAPACITY];
	logic [ils_pkg::OP_W-1:0]      op_q;
	logic [ils_pkg::IDX_W-1:0]     idx_q;
	logic [VALUE_BITS-1:0]         val_q;
	logic [VALUE_BITS-1:0]         rdata_q;
	logic [AW-1:0]                 ptr_q;
	logic [CW-1:0]                 count_q;
	logic                          out_valid_q;
	logic [ils_pkg::VAL_W-1:0]     rv_q;
	logic [ils_pkg::ST_W-1:0]      st_q;
	logic [ils_pkg::CNT_W-1:0]     cnt_q;

	logic signed [ils_pkg::WIDE_W-1:0] val_wide;
	logic signed [VALUE_BITS-1:0]      rdata_s;
	logic signed [ils_pkg::WIDE_W-1:0] rd_wide;
	logic [XW-1:0] idx_x, cnt_x, pos_x, ptr_x, cnt_m1, idx_p1, new_x;
	logic [AW-1:0] ra, wa;
	logic [VALUE_BITS-1:0] wd;
	logic rd_ok, ins_ok, full;
	logic [1:0] kind;
	logic [ils_pkg::ST_W-1:0] st_d;
	logic [ils_pkg::VAL_W-1:0] rv_d;

	assign val_wide = ils_pkg::WIDE_W'(value);
	assign rdata_s  = rdata_q;
	assign rd_wide  = ils_pkg::WIDE_W'(rdata_s);

	assign idx_x  = XW'(idx_q);
	assign cnt_x  = XW'(count_q);
	assign ptr_x  = XW'(ptr_q);
	assign cnt_m1 = cnt_x - XW'(1);
	assign idx_p1 = idx_x + XW'(1);

	always_comb begin
		unique case (op_q)
			ils_pkg::OP_FRONT: pos_x = '0;
			ils_pkg::OP_BACK:  pos_x = cnt_x;
			default:           pos_x = idx_x;
		endcase
	end

	always_comb begin
		unique case (op_q)
			ils_pkg::OP_READ:   kind = ils_pkg::K_READ;
			ils_pkg::OP_FRONT:  kind = ils_pkg::K_INS;
			ils_pkg::OP_BACK:   kind = ils_pkg::K_INS;
			ils_pkg::OP_AT:     kind = ils_pkg::K_INS;
			ils_pkg::OP_DELETE: kind = ils_pkg::K_DEL;
			default:            kind = ils_pkg::K_BAD;
		endcase
	end

	assign rd_ok  = idx_x < cnt_x;
	assign ins_ok = pos_x <= cnt_x;
	assign full   = cnt_x >= XW'(CAPACITY);

	always_comb begin
		stat            = '0;
		stat.kind       = kind;
		unique case (kind)
			ils_pkg::K_READ: stat.ok = rd_ok;
			ils_pkg::K_INS:  stat.ok = ins_ok;
			ils_pkg::K_DEL:  stat.ok = rd_ok;
			default:         stat.ok = 1'b0;
		endcase
		stat.full       = full;
		stat.pos_eq_cnt = pos_x == cnt_x;
		stat.ptr_eq_pos = ptr_x == pos_x;
		stat.idx_last   = idx_p1 == cnt_x;
		stat.ptr_last   = (ptr_x + XW'(1)) == cnt_x;
		stat.out_free   = !out_valid_q || !out_stall;
	end

	// Address selection
	always_comb begin
		unique case (cmd.rd_mode)
			ils_pkg::RA_CNT_M1: ra = cnt_m1[AW-1:0];
			ils_pkg::RA_PTR_M1: ra = ptr_q - AW'(1);
			ils_pkg::RA_PTR_P1: ra = ptr_q + AW'(1);
			ils_pkg::RA_IDX_P1: ra = idx_p1[AW-1:0];
			default:            ra = idx_x[AW-1:0];
		endcase
	end

	always_comb begin
		unique case (cmd.wr_mode)
			ils_pkg::WA_PTR_P1: wa = ptr_q + AW'(1);
			ils_pkg::WA_PTR_M1: wa = ptr_q - AW'(1);
			default:            wa = pos_x[AW-1:0];
		endcase
	end

	assign wd = (cmd.wr_mode == ils_pkg::WA_POS) ? val_q : rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q  <= operation;
			idx_q <= index;
			val_q <= val_wide[VALUE_BITS-1:0];
		end
		if (cmd.wr_en) begin
			mem[wa] <= wd;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[ra];
			ptr_q   <= ra;
		end
	end

	// Result and new count
	always_comb begin
		new_x = cnt_x;
		rv_d  = '0;
		st_d  = ils_pkg::ST_DONE;
		unique case (kind)
			ils_pkg::K_READ: begin
				if (rd_ok) begin
					rv_d = rd_wide[ils_pkg::VAL_W-1:0];
				end else begin
					rv_d = '1;
					st_d = ils_pkg::ST_RANGE;
				end
			end
			ils_pkg::K_INS: begin
				if (!ins_ok) begin
					st_d = ils_pkg::ST_RANGE;
				end else if (full) begin
					st_d = ils_pkg::ST_FULL;
				end else begin
					new_x = cnt_x + XW'(1);
				end
			end
			ils_pkg::K_DEL: begin
				if (rd_ok) begin
					new_x = cnt_m1;
				end else begin
					st_d = ils_pkg::ST_RANGE;
				end
			end
			default: st_d = ils_pkg::ST_RANGE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			count_q     <= new_x[CW-1:0];
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rv_q  <= rv_d;
			st_q  <= st_d;
			cnt_q <= new_x[ils_pkg::CNT_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = rv_q;
	assign status     = st_q;
	assign count      = cnt_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= XW'(CAPACITY))
		else $error("entry count above capacity");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=>
			(out_valid_q && $stable(rv_q) && $stable(st_q) && $stable(cnt_q)))
		else $error("stalled result changed");

	a_count_load: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.res_load |=> $stable(count_q))
		else $error("count moved without a result");

endmodule

@@ rtl/ils_ctrl.sv @@
// Controller: sequences evaluation, entry shifting and result hand-off.
module ils_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ils_pkg::ils_stat_t stat,
	output ils_pkg::ils_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_INS  = 3'd2;
	localparam logic [2:0] S_PUT  = 3'd3;
	localparam logic [2:0] S_DEL  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = S_FIN;
				unique case (stat.kind)
					ils_pkg::K_READ: begin
						if (stat.ok) begin
							cmd.rd_en   = 1'b1;
							cmd.rd_mode = ils_pkg::RA_IDX;
						end
					end
					ils_pkg::K_INS: begin
						if (stat.ok && !stat.full) begin
							if (stat.pos_eq_cnt) begin
								cmd.wr_en   = 1'b1;
								cmd.wr_mode = ils_pkg::WA_POS;
							end else begin
								cmd.rd_en   = 1'b1;
								cmd.rd_mode = ils_pkg::RA_CNT_M1;
								state_d     = S_INS;
							end
						end
					end
					ils_pkg::K_DEL: begin
						if (stat.ok && !stat.idx_last) begin
							cmd.rd_en   = 1'b1;
							cmd.rd_mode = ils_pkg::RA_IDX_P1;
							state_d     = S_DEL;
						end
					end
					default: state_d = S_FIN;
				endcase
			end
			S_INS: begin
				// move entry at ptr up one place, fetch the next one down
				cmd.wr_en   = 1'b1;
				cmd.wr_mode = ils_pkg::WA_PTR_P1;
				if (stat.ptr_eq_pos) begin
					state_d = S_PUT;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_mode = ils_pkg::RA_PTR_M1;
				end
			end
			S_PUT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_mode = ils_pkg::WA_POS;
				state_d     = S_FIN;
			end
			S_DEL: begin
				// move entry at ptr down one place, fetch the next one up
				cmd.wr_en   = 1'b1;
				cmd.wr_mode = ils_pkg::WA_PTR_M1;
				if (stat.ptr_last) begin
					state_d = S_FIN;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_mode = ils_pkg::RA_PTR_P1;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> stat.out_free)
		else $error("result loaded over an untaken result");

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_EVAL))
		else $error("accepted item not evaluated");

	a_put_after_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS && stat.ptr_eq_pos) |=>
			(cmd.wr_en && cmd.wr_mode == ils_pkg::WA_POS))
		else $error("insert value not written after shift");

endmodule

@@ rtl/indexed_list_store.sv @@
// Top level of the indexed list store: an ordered list of signed values with indexed access.
//
// Input channel: in_valid / in_stall with operation, index and value. An item is taken
// at a clock edge where in_valid is high and in_stall low. Operations: read at index,
// insert at front, insert at back, insert at index, delete at index.
// Output channel: out_valid / out_stall with read_value, status and count; every
// accepted item gives exactly one result item, in order.
// Sequencing: one item is worked on at a time. Reads, rejected requests, inserts at the
// tail and deletes of the last entry go straight from evaluation to the final step. Other
// inserts and deletes first shift entries one per cycle through the single-write,
// single-read entry memory; the longest case is an insert at the front of a list one
// short of full. The next item is taken in the idle state after the result is loaded.
// The result sits in an output register, so the next item is taken while the previous
// result still waits; a stalled receiver only holds the block at its final step.
// Reset (arst_n low, asynchronous) empties the list and drops any pending result; the
// entry memory itself is not cleared, only entries below the count are ever read.
module indexed_list_store #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [ils_pkg::OP_W-1:0]         operation,
	input  logic [ils_pkg::IDX_W-1:0]        index,
	input  logic signed [ils_pkg::VAL_W-1:0] value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [ils_pkg::VAL_W-1:0] read_value,
	output logic [ils_pkg::ST_W-1:0]         status,
	output logic [ils_pkg::CNT_W-1:0]        count
);

	ils_pkg::ils_cmd_t  cmd;
	ils_pkg::ils_stat_t stat;

	// Sequencer
	ils_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Storage, pointer arithmetic and result register
	ils_dpath #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.operation  (operation),
		.index      (index),
		.value      (value),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.read_value (read_value),
		.status     (status),
		.count      (count)
	);

endmodule
